// ===== rtl/two_body_excitation_energy_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the two-body excitation energy unit
// Thin wrappers around concurrent assertions clocked on the block clock.
// ----------------------------------------------------------------------------
`ifndef TWO_BODY_EXCITATION_ENERGY_UNIT_ASSERT_SVH
`define TWO_BODY_EXCITATION_ENERGY_UNIT_ASSERT_SVH

// property that must hold at every edge out of reset
`define TBEE_ALWAYS(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// same-cycle implication
`define TBEE_IMPLY(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TBEE_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/tbee_pkg.sv =====
// ----------------------------------------------------------------------------
// tbee_pkg
// Types, constants and helper functions shared by the excitation energy unit.
// ----------------------------------------------------------------------------
package tbee_pkg;

    // field widths
    localparam int KE_W  = 18;
    localparam int ANG_W = 15;
    localparam int FQ_W  = 16;
    localparam int ION_W = 16;
    localparam int EX_W  = 18;
    localparam int ST_W  = 2;
    localparam int BE_W  = 22;
    localparam int M_W   = 26;
    localparam int CUT_W = 16;

    // port widths
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;
    localparam int S_TDATA_W  = 72;
    localparam int M_TDATA_W  = 24;
    localparam int M_TUSER_W  = 2;

    // default sizing
    localparam int CORDIC_STEPS_DEF = 30;
    localparam int WIDE_BITS_DEF    = 128;
    localparam int QUEUE_DEPTH      = 4;

    // datapath sizing
    localparam int Q_BITS    = 96;   // momentum product p1^2 * p3^2
    localparam int SQ_STAGES = 24;   // two root bits per stage, 48-bit root
    localparam int RS_STAGES = 15;   // two root bits per stage, 30-bit root
    localparam int A_BITS    = 60;   // radicand of the final root
    localparam int SROOT_W   = 48;
    localparam int SREM_W    = 52;
    localparam int CW        = 34;   // CORDIC x, y, z

    // result status codes
    localparam logic [ST_W-1:0] ST_OK     = 2'd0;
    localparam logic [ST_W-1:0] ST_GATE   = 2'd1;
    localparam logic [ST_W-1:0] ST_ION    = 2'd2;
    localparam logic [ST_W-1:0] ST_UNPHYS = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BEAM_ENERGY   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BEAM_MASS     = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_MASS   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EJECTILE_MASS = 8'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RESIDUAL_MASS = 8'd4;
    localparam logic [CFG_IDX_W-1:0] REG_QUALITY_CUT   = 8'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ION_LOW       = 8'd6;
    localparam logic [CFG_IDX_W-1:0] REG_ION_HIGH      = 8'd7;

    // register reset values
    localparam logic [BE_W-1:0]  RST_BEAM_ENERGY   = 22'd192000;
    localparam logic [M_W-1:0]   RST_BEAM_MASS     = 26'd14917600;
    localparam logic [M_W-1:0]   RST_TARGET_MASS   = 26'd938783;
    localparam logic [M_W-1:0]   RST_EJECTILE_MASS = 26'd938783;
    localparam logic [M_W-1:0]   RST_RESIDUAL_MASS = 26'd14917600;
    localparam logic [CUT_W-1:0] RST_QUALITY_CUT   = 16'd1280;
    localparam logic [CUT_W-1:0] RST_ION_LOW       = 16'd950;
    localparam logic [CUT_W-1:0] RST_ION_HIGH      = 16'd1350;

    // angle folding, hundredths of a degree
    localparam int ANG_FULL    = 36000;
    localparam int ANG_HALF    = 18000;
    localparam int ANG_QUARTER = 9000;

    // z = floor((a * pi_q30 + 9000) / 18000) = a * Z_MUL + floor((a * Z_FRAC + 9000) / 18000)
    localparam int     Z_MUL  = 187403;
    localparam int     Z_FRAC = 5426;
    localparam int     Z_BIAS = 9000;
    localparam int     DIV_C  = 18000;
    localparam longint REC_M  = 61083979;   // floor(2^40 / 18000)
    localparam int     REC_SH = 40;

    localparam longint CORDIC_GAIN = 652032874;
    localparam longint Q30_ONE     = 1073741824;
    localparam longint HALF_Q30    = 536870912;

    // register file seen by the datapath
    typedef struct packed {
        logic [BE_W-1:0]  beam_energy;
        logic [M_W-1:0]   beam_mass;
        logic [M_W-1:0]   target_mass;
        logic [M_W-1:0]   ejectile_mass;
        logic [M_W-1:0]   residual_mass;
        logic [CUT_W-1:0] quality_cut;
        logic [CUT_W-1:0] ion_low;
        logic [CUT_W-1:0] ion_high;
    } cfg_t;

    // classified request passed from front to back
    typedef struct packed {
        logic [KE_W-1:0]  ke;
        logic [ANG_W-1:0] ang;
        logic [ST_W-1:0]  st;
    } item_t;

    // digit-by-digit square root state
    typedef struct packed {
        logic [SREM_W-1:0]  rem;
        logic [SROOT_W-1:0] root;
    } sq_t;

    // atan(2^-i) in Q30
    function automatic logic signed [CW-1:0] atan_q30(input int i);
        logic signed [CW-1:0] r;
        case (i)
            0:  r = 34'sd843314857;
            1:  r = 34'sd497837829;
            2:  r = 34'sd263043837;
            3:  r = 34'sd133525159;
            4:  r = 34'sd67021687;
            5:  r = 34'sd33543516;
            6:  r = 34'sd16775851;
            7:  r = 34'sd8388437;
            8:  r = 34'sd4194283;
            9:  r = 34'sd2097149;
            10: r = 34'sd1048576;
            default: r = (i <= 30) ? $signed(CW'(1) << (30 - i)) : '0;
        endcase
        return r;
    endfunction

    // one restoring square root step, two radicand bits in
    function automatic sq_t sqrt_step(input sq_t s, input logic [1:0] d);
        sq_t o;
        logic [SREM_W-1:0] r;
        logic [SREM_W-1:0] t;
        r = {s.rem[SREM_W-3:0], d};
        t = {2'b00, s.root, 2'b01};
        if (r >= t) begin
            o.rem  = r - t;
            o.root = {s.root[SROOT_W-2:0], 1'b1};
        end else begin
            o.rem  = r;
            o.root = {s.root[SROOT_W-2:0], 1'b0};
        end
        return o;
    endfunction

endpackage

// ===== rtl/tbee_front.sv =====
// ----------------------------------------------------------------------------
// tbee_front
// Takes input requests, unpacks them and applies the quality and ion gates.
// ----------------------------------------------------------------------------
module tbee_front (
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [tbee_pkg::S_TDATA_W-1:0]    s_tdata,
    input  tbee_pkg::cfg_t                    cfg,
    input  logic                              q_full,
    output logic                              push,
    output tbee_pkg::item_t                   push_item
);
    import tbee_pkg::*;

    logic [KE_W-1:0]  ke;
    logic [ANG_W-1:0] ang;
    logic [FQ_W-1:0]  fq;
    logic [ION_W-1:0] ion;

    assign ke  = s_tdata[KE_W-1:0];
    assign ang = s_tdata[KE_W+ANG_W-1:KE_W];
    assign fq  = s_tdata[KE_W+ANG_W+FQ_W-1:KE_W+ANG_W];
    assign ion = s_tdata[KE_W+ANG_W+FQ_W+ION_W-1:KE_W+ANG_W+FQ_W];

    // accept whenever the queue has room
    assign s_tready = !q_full;
    assign push     = s_tvalid && !q_full;

    // gate classification
    always_comb begin
        push_item.ke  = ke;
        push_item.ang = ang;
        if (fq > cfg.quality_cut || ke == '0) begin
            push_item.st = ST_GATE;
        end else if (cfg.ion_low != '0 && (ion < cfg.ion_low || ion > cfg.ion_high)) begin
            push_item.st = ST_ION;
        end else begin
            push_item.st = ST_OK;
        end
    end

endmodule

// ===== rtl/tbee_queue.sv =====
// ----------------------------------------------------------------------------
// tbee_queue
// Short FIFO of classified requests between the front and the datapath.
// ----------------------------------------------------------------------------
module tbee_queue #(
    parameter int DEPTH = tbee_pkg::QUEUE_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  tbee_pkg::item_t   push_item,
    input  logic              pop,
    output tbee_pkg::item_t   head,
    output logic              full,
    output logic              empty
);
    import tbee_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    item_t          mem_reg [0:DEPTH-1];
    logic [AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [AW:0]    count_reg, count_next;

    assign full  = (count_reg == (AW+1)'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    // pointer and fill level
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

`include "two_body_excitation_energy_unit_assert.svh"

    `TBEE_ALWAYS(a_q_level, aclk, aresetn, count_reg <= (AW+1)'(DEPTH), "queue over depth")
    `TBEE_IMPLY(a_q_push, aclk, aresetn, push, !full, "push into full queue")
    `TBEE_IMPLY(a_q_pop, aclk, aresetn, pop, !empty, "pop from empty queue")

endmodule

// ===== rtl/tbee_back.sv =====
// ----------------------------------------------------------------------------
// tbee_back
// Pipelined kinematics: cosine by CORDIC, momentum product root, invariant
// mass, final rounded root and saturation. The whole pipe stalls together.
// ----------------------------------------------------------------------------
module tbee_back #(
    parameter int CORDIC_STEPS = tbee_pkg::CORDIC_STEPS_DEF,
    parameter int WIDE_BITS    = tbee_pkg::WIDE_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  tbee_pkg::cfg_t                  cfg,
    input  logic                            q_empty,
    input  tbee_pkg::item_t                 q_head,
    output logic                            pop,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [tbee_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic [tbee_pkg::M_TUSER_W-1:0]  m_tuser
);
    import tbee_pkg::*;

    localparam int NS = (CORDIC_STEPS > SQ_STAGES) ? CORDIC_STEPS : SQ_STAGES;

    logic en;

    // ---------------- stage 1: fold angle, momentum squares ----------------
    logic             s1_vld_reg;
    logic [ST_W-1:0]  s1_st_reg;
    logic [KE_W-1:0]  s1_ke_reg;
    logic             s1_neg_reg;
    logic [25:0]      s1_n_reg;
    logic [30:0]      s1_base_reg;
    logic [49:0]      s1_p1_reg;
    logic [45:0]      s1_p3_reg;

    logic [15:0]      a_f1;
    logic [13:0]      a_f2;
    logic             neg_f;
    logic [27:0]      p1b;
    logic [27:0]      p3b;

    assign pop = en && !q_empty;

    // angle into the first quadrant
    always_comb begin
        a_f1  = {1'b0, q_head.ang};
        if (a_f1 > 16'(ANG_HALF)) begin
            a_f1 = 16'(ANG_FULL) - a_f1;
        end
        neg_f = 1'b0;
        a_f2  = a_f1[13:0];
        if (a_f1 > 16'(ANG_QUARTER)) begin
            a_f2  = 14'(16'(ANG_HALF) - a_f1);
            neg_f = 1'b1;
        end
    end

    assign p1b = 28'(cfg.beam_energy) + {1'b0, cfg.beam_mass, 1'b0};
    assign p3b = 28'(q_head.ke) + {1'b0, cfg.ejectile_mass, 1'b0};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
        end else if (en) begin
            s1_vld_reg <= pop;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_st_reg   <= q_head.st;
            s1_ke_reg   <= q_head.ke;
            s1_neg_reg  <= neg_f;
            s1_n_reg    <= 26'(a_f2) * 26'(Z_FRAC) + 26'(Z_BIAS);
            s1_base_reg <= 31'(a_f2) * 31'(Z_MUL);
            s1_p1_reg   <= 50'(cfg.beam_energy) * 50'(p1b);
            s1_p3_reg   <= 46'(q_head.ke) * 46'(p3b);
        end
    end

    // ---------------- stage 2: reciprocal estimate, partial products --------
    logic             s2_vld_reg;
    logic [ST_W-1:0]  s2_st_reg;
    logic [KE_W-1:0]  s2_ke_reg;
    logic             s2_neg_reg;
    logic [25:0]      s2_n_reg;
    logic [30:0]      s2_base_reg;
    logic [11:0]      s2_qest_reg;
    logic [47:0]      s2_pp0_reg, s2_pp1_reg, s2_pp2_reg, s2_pp3_reg;
    logic [51:0]      nm;

    assign nm = 52'(s1_n_reg) * 52'(REC_M);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_vld_reg <= 1'b0;
        end else if (en) begin
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s2_st_reg   <= s1_st_reg;
            s2_ke_reg   <= s1_ke_reg;
            s2_neg_reg  <= s1_neg_reg;
            s2_n_reg    <= s1_n_reg;
            s2_base_reg <= s1_base_reg;
            s2_qest_reg <= nm[REC_SH+11:REC_SH];
            s2_pp0_reg  <= 48'(s1_p1_reg[24:0]) * 48'(s1_p3_reg[22:0]);
            s2_pp1_reg  <= 48'(s1_p1_reg[24:0]) * 48'(s1_p3_reg[45:23]);
            s2_pp2_reg  <= 48'(s1_p1_reg[49:25]) * 48'(s1_p3_reg[22:0]);
            s2_pp3_reg  <= 48'(s1_p1_reg[49:25]) * 48'(s1_p3_reg[45:23]);
        end
    end

    // ---------------- stage 3: angle correction, product sum ---------------
    logic             c_vld_reg [0:NS];
    logic [ST_W-1:0]  c_st_reg  [0:NS];
    logic [KE_W-1:0]  c_ke_reg  [0:NS];
    logic             c_neg_reg [0:NS];
    logic signed [CW-1:0] c_x_reg [0:NS];
    logic signed [CW-1:0] c_y_reg [0:NS];
    logic signed [CW-1:0] c_z_reg [0:NS];
    logic [WIDE_BITS-1:0] c_q_reg [0:NS];
    sq_t              c_sq_reg  [0:NS];

    logic [25:0]      z_rem;
    logic [30:0]      z_ang;
    logic [Q_BITS-1:0] q_sum;

    assign z_rem = s2_n_reg - 26'(s2_qest_reg) * 26'(DIV_C);
    assign z_ang = s2_base_reg + 31'(s2_qest_reg) + 31'(z_rem >= 26'(DIV_C));
    assign q_sum = Q_BITS'(s2_pp0_reg) + (Q_BITS'(s2_pp1_reg) << 23)
                 + (Q_BITS'(s2_pp2_reg) << 25) + (Q_BITS'(s2_pp3_reg) << 48);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_vld_reg[0] <= 1'b0;
        end else if (en) begin
            c_vld_reg[0] <= s2_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c_st_reg[0]  <= s2_st_reg;
            c_ke_reg[0]  <= s2_ke_reg;
            c_neg_reg[0] <= s2_neg_reg;
            c_x_reg[0]   <= CW'(CORDIC_GAIN);
            c_y_reg[0]   <= '0;
            c_z_reg[0]   <= $signed(CW'(z_ang));
            c_q_reg[0]   <= WIDE_BITS'(q_sum);
            c_sq_reg[0]  <= '0;
        end
    end

    // ---------------- CORDIC steps and momentum root, in lockstep ----------
    for (genvar j = 0; j < NS; j++) begin : g_cs
        logic signed [CW-1:0] x_n, y_n, z_n;
        logic [WIDE_BITS-1:0] q_n;
        sq_t                  sq_n;

        always_comb begin
            x_n = c_x_reg[j];
            y_n = c_y_reg[j];
            z_n = c_z_reg[j];
            if (j < CORDIC_STEPS) begin
                if (!c_z_reg[j][CW-1]) begin
                    x_n = c_x_reg[j] - (c_y_reg[j] >>> j);
                    y_n = c_y_reg[j] + (c_x_reg[j] >>> j);
                    z_n = c_z_reg[j] - atan_q30(j);
                end else begin
                    x_n = c_x_reg[j] + (c_y_reg[j] >>> j);
                    y_n = c_y_reg[j] - (c_x_reg[j] >>> j);
                    z_n = c_z_reg[j] + atan_q30(j);
                end
            end
        end

        always_comb begin
            q_n  = c_q_reg[j];
            sq_n = c_sq_reg[j];
            if (j < SQ_STAGES) begin
                sq_n = sqrt_step(sqrt_step(c_sq_reg[j], c_q_reg[j][Q_BITS-1:Q_BITS-2]),
                                 c_q_reg[j][Q_BITS-3:Q_BITS-4]);
                q_n  = c_q_reg[j] << 4;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                c_vld_reg[j+1] <= 1'b0;
            end else if (en) begin
                c_vld_reg[j+1] <= c_vld_reg[j];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                c_st_reg[j+1]  <= c_st_reg[j];
                c_ke_reg[j+1]  <= c_ke_reg[j];
                c_neg_reg[j+1] <= c_neg_reg[j];
                c_x_reg[j+1]   <= x_n;
                c_y_reg[j+1]   <= y_n;
                c_z_reg[j+1]   <= z_n;
                c_q_reg[j+1]   <= q_n;
                c_sq_reg[j+1]  <= sq_n;
            end
        end
    end

    // ---------------- stage 4: cosine, momentum and mass products ----------
    logic             s4_vld_reg;
    logic [ST_W-1:0]  s4_st_reg;
    logic             s4_cneg_reg;
    logic [48:0]      s4_hi_reg;
    logic [60:0]      s4_lo_reg;
    logic [51:0]      s4_m1sq_reg, s4_m2sq_reg, s4_m3sq_reg;
    logic [52:0]      s4_m2e1_reg, s4_m2e3_reg;
    logic [53:0]      s4_e1e3_reg;

    logic signed [CW-1:0] x_cl, cos_v;
    logic             c_is_neg;
    logic [30:0]      cabs;
    logic [SROOT_W-1:0] s_root;
    logic [26:0]      e1, e3;

    always_comb begin
        x_cl = c_x_reg[NS];
        if (x_cl > CW'(Q30_ONE)) begin
            x_cl = CW'(Q30_ONE);
        end else if (x_cl < -$signed(CW'(Q30_ONE))) begin
            x_cl = -$signed(CW'(Q30_ONE));
        end
        cos_v    = c_neg_reg[NS] ? -x_cl : x_cl;
        c_is_neg = cos_v[CW-1];
        cabs     = 31'(c_is_neg ? -cos_v : cos_v);
    end

    assign s_root = c_sq_reg[NS].root;
    assign e1     = 27'(cfg.beam_energy) + 27'(cfg.beam_mass);
    assign e3     = 27'(c_ke_reg[NS]) + 27'(cfg.ejectile_mass);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s4_vld_reg <= 1'b0;
        end else if (en) begin
            s4_vld_reg <= c_vld_reg[NS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s4_st_reg   <= c_st_reg[NS];
            s4_cneg_reg <= c_is_neg;
            s4_hi_reg   <= 49'(s_root[47:30]) * 49'(cabs);
            s4_lo_reg   <= 61'(s_root[29:0]) * 61'(cabs);
            s4_m1sq_reg <= 52'(cfg.beam_mass) * 52'(cfg.beam_mass);
            s4_m2sq_reg <= 52'(cfg.target_mass) * 52'(cfg.target_mass);
            s4_m3sq_reg <= 52'(cfg.ejectile_mass) * 52'(cfg.ejectile_mass);
            s4_m2e1_reg <= 53'(cfg.target_mass) * 53'(e1);
            s4_m2e3_reg <= 53'(cfg.target_mass) * 53'(e3);
            s4_e1e3_reg <= 54'(e1) * 54'(e3);
        end
    end

    // ---------------- stage 5: momentum term, positive and negative sums ---
    logic             s5_vld_reg;
    logic [ST_W-1:0]  s5_st_reg;
    logic             s5_cneg_reg;
    logic [48:0]      s5_pmag_reg;
    logic [55:0]      s5_pos_reg;
    logic [56:0]      s5_neg_reg;
    logic [60:0]      lo_rnd;

    assign lo_rnd = s4_lo_reg + 61'(HALF_Q30);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s5_vld_reg <= 1'b0;
        end else if (en) begin
            s5_vld_reg <= s4_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s5_st_reg   <= s4_st_reg;
            s5_cneg_reg <= s4_cneg_reg;
            s5_pmag_reg <= s4_hi_reg + 49'(lo_rnd[60:30]);
            s5_pos_reg  <= 56'(s4_m1sq_reg) + 56'(s4_m2sq_reg) + 56'(s4_m3sq_reg)
                         + {2'b00, s4_m2e1_reg, 1'b0};
            s5_neg_reg  <= {3'b000, s4_m2e3_reg, 1'b0} + {2'b00, s4_e1e3_reg, 1'b0};
        end
    end

    // ---------------- stage 6: invariant mass squared ----------------------
    logic             r_vld_reg [0:RS_STAGES];
    logic [ST_W-1:0]  r_st_reg  [0:RS_STAGES];
    logic [A_BITS-1:0] r_a_reg  [0:RS_STAGES];
    sq_t              r_sq_reg  [0:RS_STAGES];

    logic signed [63:0] msq;
    logic signed [63:0] pterm;

    assign pterm = $signed({14'b0, s5_pmag_reg, 1'b0});
    assign msq   = $signed({8'b0, s5_pos_reg}) - $signed({7'b0, s5_neg_reg})
                 + (s5_cneg_reg ? -pterm : pterm);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r_vld_reg[0] <= 1'b0;
        end else if (en) begin
            r_vld_reg[0] <= s5_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            r_st_reg[0] <= (s5_st_reg == ST_OK && msq[63]) ? ST_UNPHYS : s5_st_reg;
            r_a_reg[0]  <= msq[A_BITS-1:0];
            r_sq_reg[0] <= '0;
        end
    end

    // ---------------- final root, two bits per stage ------------------------
    for (genvar k = 0; k < RS_STAGES; k++) begin : g_rs
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                r_vld_reg[k+1] <= 1'b0;
            end else if (en) begin
                r_vld_reg[k+1] <= r_vld_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                r_st_reg[k+1] <= r_st_reg[k];
                r_a_reg[k+1]  <= r_a_reg[k] << 4;
                r_sq_reg[k+1] <= sqrt_step(sqrt_step(r_sq_reg[k],
                                     r_a_reg[k][A_BITS-1:A_BITS-2]),
                                     r_a_reg[k][A_BITS-3:A_BITS-4]);
            end
        end
    end

    // ---------------- round to nearest ---------------------------------------
    logic             f1_vld_reg;
    logic [ST_W-1:0]  f1_st_reg;
    logic [30:0]      f1_r_reg;
    logic             rnd_up;

    assign rnd_up = r_sq_reg[RS_STAGES].rem > SREM_W'(r_sq_reg[RS_STAGES].root);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_vld_reg <= 1'b0;
        end else if (en) begin
            f1_vld_reg <= r_vld_reg[RS_STAGES];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f1_st_reg <= r_st_reg[RS_STAGES];
            f1_r_reg  <= 31'(r_sq_reg[RS_STAGES].root[29:0]) + 31'(rnd_up);
        end
    end

    // ---------------- output register: subtract, saturate -----------------
    logic             out_vld_reg;
    logic [EX_W-1:0]  out_ex_reg;
    logic [ST_W-1:0]  out_st_reg;
    logic signed [32:0] ex_full;
    logic [EX_W-1:0]  ex_sat;

    assign en = !out_vld_reg || m_tready;

    assign ex_full = $signed({2'b00, f1_r_reg}) - $signed({7'b0, cfg.residual_mass});

    always_comb begin
        if (ex_full > 33'sd131071) begin
            ex_sat = 18'h1FFFF;
        end else if (ex_full < -33'sd131072) begin
            ex_sat = 18'h20000;
        end else begin
            ex_sat = ex_full[EX_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (en) begin
            out_vld_reg <= f1_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_st_reg <= f1_st_reg;
            out_ex_reg <= (f1_st_reg == ST_OK) ? ex_sat : '0;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {6'b0, out_ex_reg};
    assign m_tuser  = out_st_reg;

`include "two_body_excitation_energy_unit_assert.svh"

    `TBEE_IMPLY(a_rej_zero, aclk, aresetn, out_vld_reg && out_st_reg != ST_OK, out_ex_reg == '0, "rejected result carries nonzero excitation")
    `TBEE_NEXT(a_stall_hold, aclk, aresetn, !en, $stable(s1_vld_reg) && $stable(f1_vld_reg), "pipe moved while stalled")
    `TBEE_IMPLY(a_pop_en, aclk, aresetn, pop, en && !q_empty, "pop without pipe advance")

endmodule

// ===== rtl/two_body_excitation_energy_unit.sv =====
// ----------------------------------------------------------------------------
// two_body_excitation_energy_unit
// Gates each detected ejectile and computes the residual excitation energy by
// relativistic two-body missing-mass kinematics.
// ----------------------------------------------------------------------------
//  channel   direction  contents
//  s_*       in         tdata: ejectile_energy, lab_angle, fit_quality, ion_value
//  m_*       out        tdata: excitation; tuser: status
//  cfg_*     in         register index and write data
//
//  While m_tready is held high, one request per cycle is accepted and one result
//  per cycle is delivered. The CORDIC chain runs beside the 48-bit momentum root
//  and is followed by the 15-stage final root.
//  Reset is synchronous, active low; it clears valid bits and loads defaults.
//  A stall on m_tready freezes the whole datapath; the front keeps filling the
//  four-entry queue until it is full.
// ----------------------------------------------------------------------------
module two_body_excitation_energy_unit #(
    parameter int CORDIC_STEPS = tbee_pkg::CORDIC_STEPS_DEF,
    parameter int WIDE_BITS    = tbee_pkg::WIDE_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // ejectile_energy[17:0], lab_angle[32:18], fit_quality[48:33], ion_value[64:49]
    input  logic [tbee_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // excitation[17:0]
    output logic [tbee_pkg::M_TDATA_W-1:0]    m_tdata,
    // status[1:0]
    output logic [tbee_pkg::M_TUSER_W-1:0]    m_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tbee_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tbee_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import tbee_pkg::*;

    cfg_t   cfg_reg;
    logic   q_full, q_empty, push, pop;
    item_t  push_item, q_head;

    assign cfg_ready = 1'b1;

    // register file
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.beam_energy   <= RST_BEAM_ENERGY;
            cfg_reg.beam_mass     <= RST_BEAM_MASS;
            cfg_reg.target_mass   <= RST_TARGET_MASS;
            cfg_reg.ejectile_mass <= RST_EJECTILE_MASS;
            cfg_reg.residual_mass <= RST_RESIDUAL_MASS;
            cfg_reg.quality_cut   <= RST_QUALITY_CUT;
            cfg_reg.ion_low       <= RST_ION_LOW;
            cfg_reg.ion_high      <= RST_ION_HIGH;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_BEAM_ENERGY:   cfg_reg.beam_energy   <= cfg_data[BE_W-1:0];
                REG_BEAM_MASS:     cfg_reg.beam_mass     <= cfg_data[M_W-1:0];
                REG_TARGET_MASS:   cfg_reg.target_mass   <= cfg_data[M_W-1:0];
                REG_EJECTILE_MASS: cfg_reg.ejectile_mass <= cfg_data[M_W-1:0];
                REG_RESIDUAL_MASS: cfg_reg.residual_mass <= cfg_data[M_W-1:0];
                REG_QUALITY_CUT:   cfg_reg.quality_cut   <= cfg_data[CUT_W-1:0];
                REG_ION_LOW:       cfg_reg.ion_low       <= cfg_data[CUT_W-1:0];
                REG_ION_HIGH:      cfg_reg.ion_high      <= cfg_data[CUT_W-1:0];
                default: ;
            endcase
        end
    end

    tbee_front u_front (
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .cfg       (cfg_reg),
        .q_full    (q_full),
        .push      (push),
        .push_item (push_item)
    );

    tbee_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (q_head),
        .full      (q_full),
        .empty     (q_empty)
    );

    tbee_back #(
        .CORDIC_STEPS (CORDIC_STEPS),
        .WIDE_BITS    (WIDE_BITS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_empty  (q_empty),
        .q_head   (q_head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb: two-body excitation energy unit
// Drives ejectile requests on the input stream and checks every result
// against a bit-exact kinematics predictor (gates, CORDIC cosine, wide root,
// rounded root, saturation). Several register settings are used, including
// extremes, with random idling on both streams.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
    import tbee_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 8'd8;   // past the register list
    localparam longint unsigned PI_Q30 = 64'd3373259426;
    localparam int DRAIN_CYCLES = 100;
    localparam int STALL_LIMIT  = 20000;
    localparam int RAND_PHASES  = 8;
    localparam int ITEMS_PER_PHASE = 230;

    typedef struct packed {
        logic [KE_W-1:0]  ke;
        logic [ANG_W-1:0] ang;
        logic [FQ_W-1:0]  fq;
        logic [ION_W-1:0] ion;
    } ejectile_t;

    typedef struct packed {
        logic signed [EX_W-1:0] ex;
        logic [ST_W-1:0]        st;
    } excitation_t;

    typedef struct {
        ejectile_t   req;
        logic        typed;
        excitation_t res;
    } directed_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // shadow of the register file
    cfg_t regs;
    excitation_t pending_results[$];
    int errors = 0;
    bit no_idle = 1'b0;
    int quiet_cycles = 0;

    two_body_excitation_energy_unit DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    function automatic longint atan_step(input int i);
        longint t[11] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                          33543516, 16775851, 8388437, 4194283, 2097149, 1048576};
        if (i < 11) return t[i];
        if (i <= 30) return longint'(1) << (30 - i);
        return 0;
    endfunction

    // cosine in Q1.30, angle folded into the first quadrant
    function automatic longint cordic_cosine(input logic [ANG_W-1:0] ang_in);
        longint unsigned a;
        longint x, y, z, dx, dy;
        bit neg;
        a = ang_in;
        neg = 1'b0;
        if (a > ANG_HALF) a = ANG_FULL - a;
        if (a > ANG_QUARTER) begin
            a = ANG_HALF - a;
            neg = 1'b1;
        end
        z = longint'((a * PI_Q30 + 9000) / 18000);
        x = CORDIC_GAIN;
        y = 0;
        for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_step(i);
            end else begin
                x += dx; y -= dy; z += atan_step(i);
            end
        end
        if (x > Q30_ONE) x = Q30_ONE;
        if (x < -Q30_ONE) x = -Q30_ONE;
        return neg ? -x : x;
    endfunction

    function automatic longint unsigned momentum_root(input logic [127:0] q);
        logic [127:0] t;
        longint unsigned r;
        r = 0;
        for (int b = 47; b >= 0; b--) begin
            t = 128'(r | (64'd1 << b));
            if (t * t <= q) r = r | (64'd1 << b);
        end
        return r;
    endfunction

    function automatic longint mass_root_rounded(input longint a);
        longint r, t;
        r = 0;
        for (int b = 29; b >= 0; b--) begin
            t = r | (longint'(1) << b);
            if (t * t <= a) r = t;
        end
        if (a - r * r > r) r++;
        return r;
    endfunction

    function automatic excitation_t predict_excitation(input ejectile_t e, input cfg_t c);
        excitation_t o;
        longint unsigned p1sq, p3sq, s, cabs, pmag;
        logic [127:0] q;
        longint cs, p, m1, m2, m3, e1, e3, msq, ex;
        o.ex = '0;
        if (e.fq > c.quality_cut || e.ke == 0) begin
            o.st = ST_GATE;
            return o;
        end
        if (c.ion_low != 0 && (e.ion < c.ion_low || e.ion > c.ion_high)) begin
            o.st = ST_ION;
            return o;
        end
        p1sq = 64'(c.beam_energy) * (64'(c.beam_energy) + 2 * 64'(c.beam_mass));
        p3sq = 64'(e.ke) * (64'(e.ke) + 2 * 64'(c.ejectile_mass));
        q = 128'(p1sq) * 128'(p3sq);
        s = momentum_root(q);
        cs = cordic_cosine(e.ang);
        cabs = (cs < 0) ? -cs : cs;
        pmag = (s >> 30) * cabs + (((s & 64'h3FFFFFFF) * cabs + 64'h20000000) >> 30);
        p = (cs < 0) ? -longint'(pmag) : longint'(pmag);
        m1 = c.beam_mass;
        m2 = c.target_mass;
        m3 = c.ejectile_mass;
        e1 = longint'(c.beam_energy) + m1;
        e3 = longint'(e.ke) + m3;
        msq = m1 * m1 + m2 * m2 + m3 * m3 + 2 * m2 * e1 - 2 * m2 * e3 - 2 * e1 * e3 + 2 * p;
        if (msq < 0) begin
            o.st = ST_UNPHYS;
            return o;
        end
        ex = mass_root_rounded(msq) - longint'(c.residual_mass);
        if (ex > 131071) ex = 131071;
        if (ex < -131072) ex = -131072;
        o.ex = ex[EX_W-1:0];
        o.st = ST_OK;
        return o;
    endfunction

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what);
        errors++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    always @(posedge aclk) begin
        excitation_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result ex=%0d st=%0d",
                                          $signed(m_tdata[EX_W-1:0]), m_tuser));
            end else begin
                want = pending_results.pop_front();
                if (m_tuser != want.st)
                    report_mismatch($sformatf("status %0d, expected %0d", m_tuser, want.st));
                if (m_tdata[EX_W-1:0] != want.ex)
                    report_mismatch($sformatf("excitation %0d, expected %0d",
                                              $signed(m_tdata[EX_W-1:0]), want.ex));
            end
        end
    end

    // result side readiness
    always @(posedge aclk) begin
        m_tready <= no_idle || ($urandom_range(99) >= 11);
    end

    // watchdog on cycles with no handshake at all
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
        cfg_index <= idx;
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_BEAM_ENERGY:   regs.beam_energy   = v[BE_W-1:0];
            REG_BEAM_MASS:     regs.beam_mass     = v[M_W-1:0];
            REG_TARGET_MASS:   regs.target_mass   = v[M_W-1:0];
            REG_EJECTILE_MASS: regs.ejectile_mass = v[M_W-1:0];
            REG_RESIDUAL_MASS: regs.residual_mass = v[M_W-1:0];
            REG_QUALITY_CUT:   regs.quality_cut   = v[CUT_W-1:0];
            REG_ION_LOW:       regs.ion_low       = v[CUT_W-1:0];
            REG_ION_HIGH:      regs.ion_high      = v[CUT_W-1:0];
            default: ;
        endcase
    endtask

    // send one request; the expectation is queued once it is taken
    task automatic send_request(input ejectile_t e, input logic typed, input excitation_t res);
        excitation_t want;
        if (!no_idle && $urandom_range(99) < 11) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tdata  <= {7'b0, e.ion, e.fq, e.ang, e.ke};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        want = predict_excitation(e, regs);
        if (typed && want != res)
            report_mismatch($sformatf("table row ke=%0d disagrees with prediction", e.ke));
        pending_results.insert(pending_results.size(), typed ? res : want);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [M_W-1:0] pick_mass();
        case ($urandom_range(3))
            0: return M_W'($urandom_range(1, 20));
            1: return '1;
            2: return M_W'($urandom_range(900000, 60000000));
            default: return M_W'($urandom);
        endcase
    endfunction

    function automatic ejectile_t random_ejectile();
        ejectile_t e;
        e.ke  = ($urandom_range(3) == 0) ? KE_W'($urandom) : KE_W'($urandom_range(1, 40000));
        e.ang = ($urandom_range(4) == 0) ? ANG_W'($urandom) : ANG_W'($urandom_range(0, 18000));
        e.fq  = FQ_W'($urandom);
        e.ion = ION_W'($urandom);
        if ($urandom_range(99) < 85) begin
            // well formed: passes the quality gate, and the ion gate unless the window is inverted
            if (e.ke == 0) e.ke = 1;
            e.fq = FQ_W'($urandom_range(0, regs.quality_cut));
            if (regs.ion_low != 0 && regs.ion_low <= regs.ion_high)
                e.ion = ION_W'($urandom_range(regs.ion_low, regs.ion_high));
        end
        return e;
    endfunction

    directed_row_t rows[$];

    function automatic directed_row_t mk(input int ke, input int ang, input int fq, input int ion,
                                         input logic typed = 1'b0,
                                         input logic [ST_W-1:0] st = ST_OK);
        directed_row_t r;
        r.req = '{ke: KE_W'(ke), ang: ANG_W'(ang), fq: FQ_W'(fq), ion: ION_W'(ion)};
        r.typed = typed;
        r.res = '{ex: '0, st: st};
        return r;
    endfunction

    initial begin
        ejectile_t e;
        regs = '{RST_BEAM_ENERGY, RST_BEAM_MASS, RST_TARGET_MASS, RST_EJECTILE_MASS,
                 RST_RESIDUAL_MASS, RST_QUALITY_CUT, RST_ION_LOW, RST_ION_HIGH};
        // gate rejects under the reset settings
        rows.insert(rows.size(), mk(5000, 4500, 1281, 1000, 1'b1, ST_GATE));
        rows.insert(rows.size(), mk(0, 4500, 0, 1000, 1'b1, ST_GATE));
        rows.insert(rows.size(), mk(262143, 32767, 65535, 65535, 1'b1, ST_GATE));
        rows.insert(rows.size(), mk(5000, 4500, 100, 949, 1'b1, ST_ION));
        rows.insert(rows.size(), mk(5000, 4500, 100, 1351, 1'b1, ST_ION));
        rows.insert(rows.size(), mk(5000, 4500, 100, 0, 1'b1, ST_ION));
        rows.insert(rows.size(), mk(5000, 4500, 100, 65535, 1'b1, ST_ION));
        // accepted events across the angle range and field extremes
        rows.insert(rows.size(), mk(5000, 0, 0, 950));
        rows.insert(rows.size(), mk(5000, 9000, 1280, 1350));
        rows.insert(rows.size(), mk(5000, 18000, 10, 1100));
        rows.insert(rows.size(), mk(5000, 18001, 10, 1100));
        rows.insert(rows.size(), mk(5000, 32767, 10, 1100));
        rows.insert(rows.size(), mk(5000, 13500, 10, 1100));
        rows.insert(rows.size(), mk(5000, 8999, 10, 1100));
        rows.insert(rows.size(), mk(1, 3000, 10, 1100));
        rows.insert(rows.size(), mk(262143, 3000, 10, 1100));
        rows.insert(rows.size(), mk(131072, 16384, 10, 1100));
        rows.insert(rows.size(), mk(20000, 2000, 10, 1100));
        rows.insert(rows.size(), mk(40000, 1, 10, 1100));

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (rows[i]) send_request(rows[i].req, rows[i].typed, rows[i].res);

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            settle();
            no_idle = (ph == 1);
            case (ph)
                0: begin
                    // realistic kinematics, ion gate disabled, stray index ignored
                    write_reg(REG_BEAM_ENERGY, 32'd150000);
                    write_reg(REG_BEAM_MASS, 32'd11177929);
                    write_reg(REG_TARGET_MASS, 32'd938272);
                    write_reg(REG_EJECTILE_MASS, 32'd938272);
                    write_reg(REG_RESIDUAL_MASS, 32'd11177929);
                    write_reg(REG_QUALITY_CUT, 32'd2000);
                    write_reg(REG_ION_LOW, 32'd0);
                    write_reg(REG_ION_HIGH, 32'd0);
                    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
                end
                1: begin
                    // everything at its top value but the ion low bound
                    write_reg(REG_BEAM_ENERGY, 32'hFFFF_FFFF);
                    write_reg(REG_BEAM_MASS, 32'hFFFF_FFFF);
                    write_reg(REG_TARGET_MASS, 32'hFFFF_FFFF);
                    write_reg(REG_EJECTILE_MASS, 32'hFFFF_FFFF);
                    write_reg(REG_RESIDUAL_MASS, 32'hFFFF_FFFF);
                    write_reg(REG_QUALITY_CUT, 32'hFFFF_FFFF);
                    write_reg(REG_ION_LOW, 32'd1);
                    write_reg(REG_ION_HIGH, 32'hFFFF_FFFF);
                end
                2: begin
                    // tiny masses and no beam: mostly unphysical
                    write_reg(REG_BEAM_ENERGY, 32'd0);
                    write_reg(REG_BEAM_MASS, 32'd1);
                    write_reg(REG_TARGET_MASS, 32'd1);
                    write_reg(REG_EJECTILE_MASS, 32'd1);
                    write_reg(REG_RESIDUAL_MASS, 32'd1);
                    write_reg(REG_QUALITY_CUT, 32'd0);
                    write_reg(REG_ION_LOW, 32'd0);
                end
                3: begin
                    // inverted ion window rejects everything that passes quality
                    write_reg(REG_BEAM_ENERGY, 32'd192000);
                    write_reg(REG_BEAM_MASS, 32'd14917600);
                    write_reg(REG_TARGET_MASS, 32'd938783);
                    write_reg(REG_EJECTILE_MASS, 32'd938783);
                    write_reg(REG_RESIDUAL_MASS, 32'd14917600);
                    write_reg(REG_QUALITY_CUT, 32'd65535);
                    write_reg(REG_ION_LOW, 32'd2000);
                    write_reg(REG_ION_HIGH, 32'd1000);
                end
                default: begin
                    write_reg(REG_BEAM_ENERGY, ($urandom_range(2) == 0) ? $urandom
                                               : $urandom_range(0, 400000));
                    write_reg(REG_BEAM_MASS, 32'(pick_mass()));
                    write_reg(REG_TARGET_MASS, 32'(pick_mass()));
                    write_reg(REG_EJECTILE_MASS, 32'(pick_mass()));
                    write_reg(REG_RESIDUAL_MASS, 32'(pick_mass()));
                    write_reg(REG_QUALITY_CUT, $urandom);
                    write_reg(REG_ION_LOW, ($urandom_range(2) == 0) ? 32'd0 : $urandom_range(0, 30000));
                    write_reg(REG_ION_HIGH, $urandom_range(20000, 65535));
                end
            endcase
            cfg_valid <= 1'b0;
            @(posedge aclk);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                e = random_ejectile();
                send_request(e, 1'b0, '0);
            end
        end
        no_idle = 1'b0;
        settle();

        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
